// File: design/mnrs_pkg.sv
package mnrs_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int NOTE_COUNT   = 128;
  localparam int HALF_NOTES   = NOTE_COUNT / 2;
  localparam int MAP_W        = 3 * MAX_CHANNELS;
  localparam int CFG_DATA_W   = MAP_W;

  // register indexes on the config port
  localparam logic [1:0] REG_SOURCE_MAP  = 2'd0;
  localparam logic [1:0] REG_SUSTAIN_CTL = 2'd1;
  localparam logic [1:0] REG_SUSTAIN_THR = 2'd2;
  localparam logic [1:0] REG_REVERB_CTL  = 2'd3;

  localparam logic [MAP_W-1:0] MAP_RESET         = 48'h9249249248D1;
  localparam logic [6:0]       SUSTAIN_CTL_RESET = 7'd64;
  localparam logic [6:0]       SUSTAIN_THR_RESET = 7'd64;
  localparam logic [6:0]       REVERB_CTL_RESET  = 7'd91;

  // status byte upper nibbles
  localparam logic [3:0] CMD_NOTE_OFF    = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON     = 4'h9;
  localparam logic [3:0] CMD_KEY_PRESS   = 4'hA;
  localparam logic [3:0] CMD_CTRL        = 4'hB;
  localparam logic [3:0] CMD_PROGRAM     = 4'hC;
  localparam logic [3:0] CMD_CH_PRESS    = 4'hD;
  localparam logic [3:0] CMD_PITCH_WHEEL = 4'hE;
  localparam logic [3:0] CMD_SYSTEM      = 4'hF;

  localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
  localparam logic [7:0] BYTE_TIMING_CLK  = 8'hF8;

  // only MIDI channels below this are note sources
  localparam logic [3:0] NOTE_CHANNELS = 4'd3;

  localparam logic [2:0] SRC_SHARED = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DATA1 = 3'd1,
    PH_DATA2 = 3'd2,
    PH_SKIP1 = 3'd3,
    PH_SYSEX = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_NOTE_ON  = 3'd0,
    EV_NOTE_OFF = 3'd1,
    EV_RELEASE  = 3'd2,
    EV_REVERB   = 3'd3,
    EV_CONTROL  = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } mnrs_in_t;

  typedef struct packed {
    event_kind_t                  event_kind;
    logic [MAX_CHANNELS-1:0]      channel_mask;
    logic [6:0]                   note_number;
    logic [6:0]                   level_value;
    logic [HALF_NOTES-1:0]        release_low;
    logic [HALF_NOTES-1:0]        release_high;
  } mnrs_out_t;

  typedef struct packed {
    logic [MAP_W-1:0] source_map;
    logic [6:0]       sustain_ctl;
    logic [6:0]       sustain_thr;
    logic [6:0]       reverb_ctl;
  } mnrs_cfg_t;

endpackage

// File: design/mnrs_in_stage.sv
module mnrs_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mnrs_pkg::mnrs_in_t in_data,
  input  logic              advance,
  output logic              item_valid,
  output mnrs_pkg::mnrs_in_t item
);

  logic               valid_r, valid_nxt;
  mnrs_pkg::mnrs_in_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

// File: design/mnrs_core.sv
module mnrs_core #(
  parameter int OUT_CHANNELS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  mnrs_pkg::mnrs_in_t  item,
  input  mnrs_pkg::mnrs_cfg_t cfg,
  output logic                res_valid,
  output mnrs_pkg::mnrs_out_t res
);

  localparam int NC = mnrs_pkg::NOTE_COUNT;
  localparam int HN = mnrs_pkg::HALF_NOTES;

  mnrs_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [6:0]       first_r, first_nxt;
  logic [NC-1:0]    pressed_r, pressed_nxt;
  logic [NC-1:0]    sustained_r, sustained_nxt;
  logic             sustain_r, sustain_nxt;

  logic [7:0]  b;
  logic [6:0]  d;
  logic [3:0]  cmd;
  logic [3:0]  ch;
  logic [2:0]  src;
  logic [NC-1:0] note_bit;
  logic [NC-1:0] release_bits;
  logic [mnrs_pkg::MAX_CHANNELS-1:0] route;

  assign b        = item.data_byte;
  assign d        = b[6:0];
  assign cmd      = status_r[7:4];
  assign ch       = status_r[3:0];
  assign src      = ch[2:0] + 3'd1;
  assign note_bit = NC'(1) << first_r;
  assign release_bits = sustained_r & ~pressed_r;

  // channel c answers its own source; entry 4 also answers sources 2 and 3
  always_comb begin
    logic [2:0] e;
    route = '0;
    for (int c = 0; c < mnrs_pkg::MAX_CHANNELS; c++) begin
      e = cfg.source_map[3*c +: 3];
      if (c < OUT_CHANNELS &&
          (e == src || (e == mnrs_pkg::SRC_SHARED && (src == 3'd2 || src == 3'd3)))) begin
        route[c] = 1'b1;
      end
    end
  end

  // parser phase
  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = status_r;
    first_nxt  = first_r;
    unique case (phase_r)
      mnrs_pkg::PH_DATA1: begin
        first_nxt = d;
        phase_nxt = mnrs_pkg::PH_DATA2;
      end
      mnrs_pkg::PH_DATA2: phase_nxt = mnrs_pkg::PH_IDLE;
      mnrs_pkg::PH_SKIP1: phase_nxt = mnrs_pkg::PH_IDLE;
      mnrs_pkg::PH_SYSEX: begin
        if (b == mnrs_pkg::BYTE_SYSEX_END) begin
          phase_nxt = mnrs_pkg::PH_IDLE;
        end
      end
      default: begin
        if (b[7] && b[7:4] != mnrs_pkg::CMD_SYSTEM) begin
          status_nxt = b;
          if (b[7:4] == mnrs_pkg::CMD_PROGRAM || b[7:4] == mnrs_pkg::CMD_CH_PRESS) begin
            phase_nxt = mnrs_pkg::PH_SKIP1;
          end else begin
            phase_nxt = mnrs_pkg::PH_DATA1;
          end
        end else if (b == mnrs_pkg::BYTE_SYSEX_START) begin
          phase_nxt = mnrs_pkg::PH_SYSEX;
        end else begin
          phase_nxt = mnrs_pkg::PH_IDLE;
        end
      end
    endcase
    if (item.end_of_buffer) begin
      phase_nxt = mnrs_pkg::PH_IDLE;
    end
  end

  // message completion: results and note bitmaps
  always_comb begin
    pressed_nxt   = pressed_r;
    sustained_nxt = sustained_r;
    sustain_nxt   = sustain_r;
    res_valid     = 1'b0;
    res           = '0;
    if (phase_r == mnrs_pkg::PH_DATA2) begin
      if (cmd == mnrs_pkg::CMD_CTRL) begin
        if (first_r == cfg.sustain_ctl) begin
          if (d >= cfg.sustain_thr) begin
            sustain_nxt   = 1'b1;
            sustained_nxt = sustained_r | pressed_r;
          end else begin
            sustain_nxt      = 1'b0;
            sustained_nxt    = '0;
            res_valid        = 1'b1;
            res.event_kind   = mnrs_pkg::EV_RELEASE;
            res.release_low  = release_bits[HN-1:0];
            res.release_high = release_bits[NC-1:HN];
          end
        end else if (first_r == cfg.reverb_ctl) begin
          res_valid       = 1'b1;
          res.event_kind  = mnrs_pkg::EV_REVERB;
          res.level_value = d;
        end else begin
          res_valid       = 1'b1;
          res.event_kind  = mnrs_pkg::EV_CONTROL;
          res.note_number = first_r;
          res.level_value = d;
        end
      end else if ((cmd == mnrs_pkg::CMD_NOTE_OFF || cmd == mnrs_pkg::CMD_NOTE_ON) &&
                   ch < mnrs_pkg::NOTE_CHANNELS) begin
        if (cmd == mnrs_pkg::CMD_NOTE_OFF || d == 7'd0) begin
          pressed_nxt = pressed_r & ~note_bit;
          if (!sustain_r) begin
            sustained_nxt    = sustained_r & ~note_bit;
            res_valid        = 1'b1;
            res.event_kind   = mnrs_pkg::EV_NOTE_OFF;
            res.channel_mask = route;
            res.note_number  = first_r;
          end
        end else begin
          pressed_nxt = pressed_r | note_bit;
          if (sustain_r) begin
            sustained_nxt = sustained_r | note_bit;
          end
          res_valid        = 1'b1;
          res.event_kind   = mnrs_pkg::EV_NOTE_ON;
          res.channel_mask = route;
          res.note_number  = first_r;
          res.level_value  = d;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= mnrs_pkg::PH_IDLE;
      status_r    <= '0;
      first_r     <= '0;
      pressed_r   <= '0;
      sustained_r <= '0;
      sustain_r   <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      status_r    <= status_nxt;
      first_r     <= first_nxt;
      pressed_r   <= pressed_nxt;
      sustained_r <= sustained_nxt;
      sustain_r   <= sustain_nxt;
    end
  end

endmodule

// File: design/mnrs_out_stage.sv
module mnrs_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                res_valid,
  input  mnrs_pkg::mnrs_out_t res,
  output logic                can_take,
  output logic                out_valid,
  input  logic                out_ready,
  output mnrs_pkg::mnrs_out_t out_data
);

  logic                valid_r, valid_nxt;
  mnrs_pkg::mnrs_out_t data_r;

  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = res_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      data_r <= res;
    end
  end

endmodule

// File: design/midi_note_router_sustain.sv
// MIDI note router with sustain pedal.
// in_*  : one received MIDI byte per item, with a flag on the last byte of
//         a receive buffer (an unfinished message there is dropped).
// out_* : at most one event per input byte, on the byte that completes a
//         note on/off or control change message.
// cfg_* : write-only register port (source map, sustain controller,
//         sustain threshold, reverb controller); write only while idle.
// Timing: an accepted byte is held in the input register; once the output
// register can take a result, the parser and bitmap logic evaluate it
// combinationally and the event is registered in the output register,
// which raises out_valid.
// One byte per cycle while the output register is not stalled; the only
// loop is the parser state, the sustain flag and the two 128-bit note bitmaps.
// A stalled receiver holds the event in the output register; the input
// register still takes one more byte, then in_ready drops until out_ready.
// Reset (synchronous, rst_n low) returns the parser to idle, clears the
// pressed and sustained bitmaps and sustain, and loads register defaults.
module midi_note_router_sustain #(
  parameter int OUT_CHANNELS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mnrs_pkg::mnrs_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mnrs_pkg::mnrs_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [mnrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mnrs_pkg::mnrs_cfg_t cfg_r;
  logic                item_valid;
  mnrs_pkg::mnrs_in_t  item;
  logic                can_take;
  logic                fire;
  logic                res_valid;
  mnrs_pkg::mnrs_out_t res;

  assign fire = item_valid && can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_map  <= mnrs_pkg::MAP_RESET;
      cfg_r.sustain_ctl <= mnrs_pkg::SUSTAIN_CTL_RESET;
      cfg_r.sustain_thr <= mnrs_pkg::SUSTAIN_THR_RESET;
      cfg_r.reverb_ctl  <= mnrs_pkg::REVERB_CTL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mnrs_pkg::REG_SOURCE_MAP:  cfg_r.source_map  <= cfg_data[mnrs_pkg::MAP_W-1:0];
        mnrs_pkg::REG_SUSTAIN_CTL: cfg_r.sustain_ctl <= cfg_data[6:0];
        mnrs_pkg::REG_SUSTAIN_THR: cfg_r.sustain_thr <= cfg_data[6:0];
        mnrs_pkg::REG_REVERB_CTL:  cfg_r.reverb_ctl  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  mnrs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  mnrs_core #(
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  mnrs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: bench/midi_note_router_sustain_tb.sv
`timescale 1ns / 1ps

module midi_note_router_sustain_tb;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_BYTES   = 160;
  localparam int SETTLE_CYCLES = 4;

  logic                            clk;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  mnrs_pkg::mnrs_in_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  mnrs_pkg::mnrs_out_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [1:0]                      cfg_index = mnrs_pkg::REG_SOURCE_MAP;
  logic [mnrs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  midi_note_router_sustain u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // parser / note state mirror
  mnrs_pkg::mnrs_cfg_t cfg_now;
  mnrs_pkg::phase_t    phase;
  logic [7:0]          held_status;
  logic [6:0]          held_d1;
  logic [127:0]        pressed;
  logic [127:0]        sustained;
  bit                  sus_on;

  mnrs_pkg::mnrs_out_t events_due[$];
  mnrs_pkg::mnrs_in_t  byte_stream[$];
  int                  err_count   = 0;
  int                  cycle_count = 0;
  bit                  in_calm     = 1'b0;
  bit                  out_calm    = 1'b0;

  typedef struct {
    mnrs_pkg::mnrs_in_t  item;
    bit                  typed;
    mnrs_pkg::mnrs_out_t ev;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic reset_model();
    cfg_now.source_map  = mnrs_pkg::MAP_RESET;
    cfg_now.sustain_ctl = mnrs_pkg::SUSTAIN_CTL_RESET;
    cfg_now.sustain_thr = mnrs_pkg::SUSTAIN_THR_RESET;
    cfg_now.reverb_ctl  = mnrs_pkg::REVERB_CTL_RESET;
    phase       = mnrs_pkg::PH_IDLE;
    held_status = '0;
    held_d1     = '0;
    pressed     = '0;
    sustained   = '0;
    sus_on      = 1'b0;
  endtask

  function automatic logic [mnrs_pkg::MAX_CHANNELS-1:0] route_mask(input logic [2:0] src);
    logic [mnrs_pkg::MAX_CHANNELS-1:0] m;
    logic [2:0]                        e;
    m = '0;
    for (int c = 0; c < mnrs_pkg::MAX_CHANNELS; c++) begin
      e = cfg_now.source_map[3*c +: 3];
      // shared entry answers the second and third note sources
      if (e == src || (e == mnrs_pkg::SRC_SHARED && (src == 3'd2 || src == 3'd3)))
        m[c] = 1'b1;
    end
    return m;
  endfunction

  function automatic bit control_event(input logic [6:0] ctl, input logic [6:0] val,
                                       output mnrs_pkg::mnrs_out_t ev);
    logic [127:0] gone;
    ev = '0;
    if (ctl == cfg_now.sustain_ctl) begin
      if (val >= cfg_now.sustain_thr) begin
        sus_on    = 1'b1;
        sustained = sustained | pressed;
        return 1'b0;
      end
      sus_on          = 1'b0;
      gone            = sustained & ~pressed;
      ev.event_kind   = mnrs_pkg::EV_RELEASE;
      ev.release_low  = gone[63:0];
      ev.release_high = gone[127:64];
      sustained       = '0;
      return 1'b1;
    end
    if (ctl == cfg_now.reverb_ctl) begin
      ev.event_kind  = mnrs_pkg::EV_REVERB;
      ev.level_value = val;
      return 1'b1;
    end
    ev.event_kind  = mnrs_pkg::EV_CONTROL;
    ev.note_number = ctl;
    ev.level_value = val;
    return 1'b1;
  endfunction

  function automatic bit finish_msg(input logic [6:0] d2, output mnrs_pkg::mnrs_out_t ev);
    logic [3:0] cmd;
    logic [3:0] ch;
    logic [2:0] src;
    bit         hit;
    cmd = held_status[7:4];
    ch  = held_status[3:0];
    ev  = '0;
    if (cmd == mnrs_pkg::CMD_CTRL)
      return control_event(held_d1, d2, ev);
    if (cmd != mnrs_pkg::CMD_NOTE_OFF && cmd != mnrs_pkg::CMD_NOTE_ON)
      return 1'b0;
    if (ch >= mnrs_pkg::NOTE_CHANNELS)
      return 1'b0;
    src = ch[2:0] + 3'd1;
    if (cmd == mnrs_pkg::CMD_NOTE_OFF || d2 == 7'd0) begin
      hit = 1'b0;
      // held pedal swallows the note off
      if (!sus_on) begin
        ev.event_kind      = mnrs_pkg::EV_NOTE_OFF;
        ev.channel_mask    = route_mask(src);
        ev.note_number     = held_d1;
        sustained[held_d1] = 1'b0;
        hit                = 1'b1;
      end
      pressed[held_d1] = 1'b0;
      return hit;
    end
    if (sus_on)
      sustained[held_d1] = 1'b1;
    pressed[held_d1] = 1'b1;
    ev.event_kind    = mnrs_pkg::EV_NOTE_ON;
    ev.channel_mask  = route_mask(src);
    ev.note_number   = held_d1;
    ev.level_value   = d2;
    return 1'b1;
  endfunction

  function automatic bit route_byte(input mnrs_pkg::mnrs_in_t it,
                                    output mnrs_pkg::mnrs_out_t ev);
    logic [7:0] b;
    bit         hit;
    b   = it.data_byte;
    hit = 1'b0;
    ev  = '0;
    case (phase)
      mnrs_pkg::PH_DATA1: begin
        held_d1 = b[6:0];
        phase   = mnrs_pkg::PH_DATA2;
      end
      mnrs_pkg::PH_DATA2: begin
        hit   = finish_msg(b[6:0], ev);
        phase = mnrs_pkg::PH_IDLE;
      end
      mnrs_pkg::PH_SKIP1: phase = mnrs_pkg::PH_IDLE;
      mnrs_pkg::PH_SYSEX: if (b == mnrs_pkg::BYTE_SYSEX_END) phase = mnrs_pkg::PH_IDLE;
      default: begin
        if (b[7] && b[7:4] != mnrs_pkg::CMD_SYSTEM) begin
          held_status = b;
          phase = (b[7:4] == mnrs_pkg::CMD_PROGRAM || b[7:4] == mnrs_pkg::CMD_CH_PRESS) ?
                  mnrs_pkg::PH_SKIP1 : mnrs_pkg::PH_DATA1;
        end else if (b == mnrs_pkg::BYTE_SYSEX_START) begin
          phase = mnrs_pkg::PH_SYSEX;
        end else begin
          phase = mnrs_pkg::PH_IDLE;
        end
      end
    endcase
    if (it.end_of_buffer)
      phase = mnrs_pkg::PH_IDLE;
    return hit;
  endfunction

  // called in step with the clock; returns once the DUT has accepted the item
  task automatic send_item(input mnrs_pkg::mnrs_in_t it, input bit typed,
                           input mnrs_pkg::mnrs_out_t typed_ev);
    int                  gap;
    bit                  hit;
    mnrs_pkg::mnrs_out_t ev;
    if ($urandom_range(0, 39) == 0)
      in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    hit = route_byte(it, ev);
    if (typed)
      events_due.push_back(typed_ev);
    else if (hit)
      events_due.push_back(ev);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (events_due.size() != 0);
    // a last byte with no event may still sit in the input register
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx,
                           input logic [mnrs_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(input mnrs_pkg::mnrs_cfg_t c);
    logic [mnrs_pkg::CFG_DATA_W-1:0] w;
    cfg_write(mnrs_pkg::REG_SOURCE_MAP, c.source_map);
    // upper data bits are don't-care for the 7-bit registers
    w = mnrs_pkg::CFG_DATA_W'({$urandom, $urandom});
    w[6:0] = c.sustain_ctl;
    cfg_write(mnrs_pkg::REG_SUSTAIN_CTL, w);
    w = mnrs_pkg::CFG_DATA_W'({$urandom, $urandom});
    w[6:0] = c.sustain_thr;
    cfg_write(mnrs_pkg::REG_SUSTAIN_THR, w);
    w = mnrs_pkg::CFG_DATA_W'({$urandom, $urandom});
    w[6:0] = c.reverb_ctl;
    cfg_write(mnrs_pkg::REG_REVERB_CTL, w);
    cfg_we  <= 1'b0;
    cfg_now  = c;
  endtask

  task automatic add_row(input logic [7:0] b, input bit eob, input bit typed,
                         input mnrs_pkg::event_kind_t k, input logic [6:0] note,
                         input logic [6:0] lvl);
    dir_row_t r;
    r.item.data_byte     = b;
    r.item.end_of_buffer = eob;
    r.typed              = typed;
    r.ev                 = '0;
    r.ev.event_kind      = k;
    r.ev.note_number     = note;
    r.ev.level_value     = lvl;
    dir_rows.push_back(r);
  endtask

  task automatic push_byte(input logic [7:0] b);
    mnrs_pkg::mnrs_in_t it;
    it.data_byte     = b;
    it.end_of_buffer = ($urandom_range(0, 19) == 0);
    byte_stream.push_back(it);
  endtask

  function automatic logic [7:0] rand_data();
    // now and then a status byte lands where data is due
    if ($urandom_range(0, 15) == 0)
      return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] rand_note();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)
      return 8'($urandom_range(60, 67));
    if (r < 7)
      return $urandom_range(0, 1) ? 8'd127 : 8'd0;
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic add_message();
    int         k;
    int         n;
    logic [3:0] ch;
    logic [6:0] thr;
    k   = $urandom_range(0, 99);
    ch  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
    thr = cfg_now.sustain_thr;
    if (k < 30) begin
      push_byte({mnrs_pkg::CMD_NOTE_ON, ch});
      push_byte(rand_note());
      push_byte(($urandom_range(0, 7) == 0) ? 8'd0 : rand_data());
    end else if (k < 45) begin
      push_byte({mnrs_pkg::CMD_NOTE_OFF, ch});
      push_byte(rand_note());
      push_byte(rand_data());
    end else if (k < 57) begin
      push_byte({mnrs_pkg::CMD_CTRL, ch});
      push_byte({1'b0, cfg_now.sustain_ctl});
      if ($urandom_range(0, 1) || thr == 7'd0)
        push_byte(8'($urandom_range(thr, 127)));
      else
        push_byte(8'($urandom_range(0, thr - 1)));
    end else if (k < 62) begin
      push_byte({mnrs_pkg::CMD_CTRL, ch});
      push_byte({1'b0, cfg_now.reverb_ctl});
      push_byte(rand_data());
    end else if (k < 72) begin
      push_byte({mnrs_pkg::CMD_CTRL, ch});
      push_byte(rand_data());
      push_byte(rand_data());
    end else if (k < 77) begin
      push_byte({$urandom_range(0, 1) ? mnrs_pkg::CMD_PROGRAM : mnrs_pkg::CMD_CH_PRESS, ch});
      push_byte(rand_data());
    end else if (k < 82) begin
      push_byte({$urandom_range(0, 1) ? mnrs_pkg::CMD_KEY_PRESS : mnrs_pkg::CMD_PITCH_WHEEL,
                 ch});
      push_byte(rand_data());
      push_byte(rand_data());
    end else if (k < 87) begin
      push_byte(mnrs_pkg::BYTE_SYSEX_START);
      n = $urandom_range(0, 4);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0)
        push_byte(mnrs_pkg::BYTE_SYSEX_END);
      else
        byte_stream[$].end_of_buffer = 1'b1;
    end else if (k < 92) begin
      push_byte(8'($urandom_range(8'hF1, 8'hFF)));
    end else if (k < 96) begin
      push_byte(8'($urandom_range(0, 127)));
    end else begin
      push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  function automatic logic [mnrs_pkg::MAP_W-1:0] rand_map();
    logic [mnrs_pkg::MAP_W-1:0] m;
    for (int c = 0; c < mnrs_pkg::MAX_CHANNELS; c++)
      m[3*c +: 3] = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(1, 4));
    return m;
  endfunction

  task automatic check_event(input mnrs_pkg::mnrs_out_t act);
    mnrs_pkg::mnrs_out_t exp;
    if (events_due.size() == 0) begin
      $error("unexpected event: kind %0d note %0d", act.event_kind, act.note_number);
      err_count++;
      return;
    end
    exp = events_due.pop_front();
    if (act.event_kind !== exp.event_kind) begin
      $error("event_kind: expected %0d, got %0d", exp.event_kind, act.event_kind);
      err_count++;
    end
    if (act.channel_mask !== exp.channel_mask) begin
      $error("channel_mask: expected %h, got %h", exp.channel_mask, act.channel_mask);
      err_count++;
    end
    if (act.note_number !== exp.note_number) begin
      $error("note_number: expected %0d, got %0d", exp.note_number, act.note_number);
      err_count++;
    end
    if (act.level_value !== exp.level_value) begin
      $error("level_value: expected %0d, got %0d", exp.level_value, act.level_value);
      err_count++;
    end
    if (act.release_low !== exp.release_low) begin
      $error("release_low: expected %h, got %h", exp.release_low, act.release_low);
      err_count++;
    end
    if (act.release_high !== exp.release_high) begin
      $error("release_high: expected %h, got %h", exp.release_high, act.release_high);
      err_count++;
    end
  endtask

  // event receiver with random back-pressure
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0)
        out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_event(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    mnrs_pkg::mnrs_cfg_t c;
    mnrs_pkg::mnrs_in_t  last;
    reset_model();

    // reset defaults: sustain ctl 64, threshold 64, reverb ctl 91
    add_row(8'h00, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'hB0, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h40, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h00, 1'b0, 1'b1, mnrs_pkg::EV_RELEASE, 7'd0, 7'd0);
    add_row(8'hB0, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h5B, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h7F, 1'b0, 1'b1, mnrs_pkg::EV_REVERB, 7'd0, 7'd127);
    add_row(8'hB5, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h07, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h64, 1'b0, 1'b1, mnrs_pkg::EV_CONTROL, 7'd7, 7'd100);
    add_row(8'h90, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h7F, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h7F, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'hB0, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h40, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h7F, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    // velocity 0 note off on ch1 while pedal is down
    add_row(8'h91, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h7F, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h00, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'hB0, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h40, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h00, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    // message cut by buffer end, then a stray data byte
    add_row(8'h90, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h3C, 1'b1, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h40, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    // status bytes taken as data, flag on the completing byte
    add_row(8'h92, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'h80, 1'b0, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);
    add_row(8'hFF, 1'b1, 1'b0, mnrs_pkg::EV_NOTE_ON, 7'd0, 7'd0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].ev);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: c = '{source_map: '1, sustain_ctl: 7'd0, sustain_thr: 7'd0, reverb_ctl: 7'd127};
        1: c = '{source_map: '0, sustain_ctl: 7'd127, sustain_thr: 7'd127, reverb_ctl: 7'd0};
        2: c = '{source_map: 48'h924924924924, sustain_ctl: 7'd20, sustain_thr: 7'd1,
                 reverb_ctl: 7'd20};
        6: c = '{source_map: mnrs_pkg::MAP_W'({$urandom, $urandom}),
                 sustain_ctl: mnrs_pkg::SUSTAIN_CTL_RESET,
                 sustain_thr: mnrs_pkg::SUSTAIN_THR_RESET,
                 reverb_ctl: mnrs_pkg::REVERB_CTL_RESET};
        7: c = '{source_map: mnrs_pkg::MAP_RESET, sustain_ctl: mnrs_pkg::SUSTAIN_CTL_RESET,
                 sustain_thr: mnrs_pkg::SUSTAIN_THR_RESET,
                 reverb_ctl: mnrs_pkg::REVERB_CTL_RESET};
        default: c = '{source_map: rand_map(), sustain_ctl: 7'($urandom_range(0, 127)),
                       sustain_thr: 7'($urandom_range(0, 127)),
                       reverb_ctl: 7'($urandom_range(0, 127))};
      endcase
      apply_config(c);

      byte_stream.delete();
      while (byte_stream.size() < PHASE_BYTES)
        add_message();
      // close the phase on a buffer end so no message spans a register change
      last.data_byte     = mnrs_pkg::BYTE_TIMING_CLK;
      last.end_of_buffer = 1'b1;
      byte_stream.push_back(last);

      foreach (byte_stream[i]) begin
        send_item(byte_stream[i], 1'b0, '0);
        if (p == 3 && i == PHASE_BYTES / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (events_due.size() != 0);
        end
      end
    end

    drain();
    if (err_count == 0 && events_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
